>>> design/empirical_cdf_index_sampler_unit_defines.svh
// Assertion macros shared by the sampler RTL.
`ifndef EMPIRICAL_CDF_INDEX_SAMPLER_UNIT_DEFINES_SVH
`define EMPIRICAL_CDF_INDEX_SAMPLER_UNIT_DEFINES_SVH

`define ECDF_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("ecdf assertion failed");

`define ECDF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("ecdf assertion failed");

`endif

>>> design/ecdf_pkg.sv
// Shared types and constants of the empirical CDF index sampler.
`timescale 1ns / 1ps
`default_nettype none

package ecdf_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int NUM_TABLES_DEF  = 4;
  localparam int NUM_POP         = 4;

  localparam int SEL_W   = 2;
  localparam int IDX_W   = 6;
  localparam int PT_W    = 17;
  localparam int U_W     = 16;
  localparam int HOST_W  = 16;
  localparam int POP_W   = 17;
  localparam int POP_MAX = 65536;
  localparam int FRAC_W  = 16;
  localparam int MUL_W   = 2 * PT_W;
  localparam int QUO_W   = 17;
  localparam int DVS_W   = PT_W + 1;
  localparam int DVD_W   = MUL_W + 2;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_SAMPLE = 1'b1
  } ecdf_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MLO,
    S_MHI,
    S_DEC,
    S_MQ,
    S_DIVST,
    S_DIVW,
    S_DONE
  } ecdf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> design/ecdf_in_if.sv
// Input channel of the sampler: load and sample words.
`timescale 1ns / 1ps
`default_nettype none

interface ecdf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ecdf_pkg::SEL_W-1:0]   table_sel;
  logic [ecdf_pkg::IDX_W-1:0]   entry_index;
  logic [ecdf_pkg::PT_W-1:0]    entry_x;
  logic [ecdf_pkg::PT_W-1:0]    entry_y;
  logic                         entry_last;
  logic [ecdf_pkg::U_W-1:0]     uniform;

  modport source (
    output valid, mode, table_sel, entry_index, entry_x, entry_y, entry_last, uniform,
    input  ready
  );
  modport sink (
    input  valid, mode, table_sel, entry_index, entry_x, entry_y, entry_last, uniform,
    output ready
  );
endinterface

`default_nettype wire

>>> design/ecdf_out_if.sv
// Result channel of the sampler: chosen host index words.
`timescale 1ns / 1ps
`default_nettype none

interface ecdf_out_if;
  logic                          valid;
  logic                          ready;
  logic [ecdf_pkg::HOST_W-1:0]   host_index;
  logic [ecdf_pkg::SEL_W-1:0]    table_used;

  modport source (
    output valid, host_index, table_used,
    input  ready
  );
  modport sink (
    input  valid, host_index, table_used,
    output ready
  );
endinterface

`default_nettype wire

>>> design/ecdf_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ecdf_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ecdf_pkg::DVD_W-1:0]  dividend,
  input  wire logic [ecdf_pkg::DVS_W-1:0]  divisor,
  output logic      [ecdf_pkg::QUO_W-1:0]  quotient,
  output ecdf_pkg::div_stat_t              stat
);

  localparam int CNT_W = $clog2(ecdf_pkg::QUO_W + 1);

  logic [ecdf_pkg::DVS_W-1:0] rem_r;
  logic [ecdf_pkg::DVS_W-1:0] dvs_r;
  logic [ecdf_pkg::QUO_W-1:0] quo_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       done_r;
  logic [ecdf_pkg::DVS_W:0]   trial;
  logic [ecdf_pkg::DVS_W:0]   diff;
  logic                       ge;
  logic [ecdf_pkg::DVS_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[ecdf_pkg::QUO_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[ecdf_pkg::DVS_W-1:0] : trial[ecdf_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(ecdf_pkg::QUO_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= ecdf_pkg::DVS_W'(dividend >> ecdf_pkg::QUO_W);
      quo_r <= dividend[ecdf_pkg::QUO_W-1:0];
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[ecdf_pkg::QUO_W-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

`default_nettype wire

>>> design/empirical_cdf_index_sampler_unit.sv
// Empirical CDF index sampler: table store, search, scaling and interpolation.
//
// in_item carries load and sample words (valid/ready). A load word writes one
// (x, y) point of a table; the point flagged last sets the count.
// A sample word searches its table for the first point whose y exceeds the
// uniform value, scales the bracketing x values by the table's population,
// interpolates with a serial divider and clamps to population - 1.
// out_item carries one word per sample: host_index and table_used.
// An empty or absent table skips the search and yields host_index 0. The scan
// reads one point a cycle from the point memory; the divider runs only when
// the hit needs interpolation. One sample is in work at a time and the next
// word is taken the cycle after the result moves to the output register; a
// load is taken in any idle cycle.
// Reset empties every table (counts to zero) and sets each population to 1.
// The point memory keeps its contents and needs no clearing pass.
// A finished word sits in the output register; while the receiver stalls the
// block still accepts the next word and holds its result until the slot frees.
// Populations are written over the APB port at byte addresses 0, 4, 8 and 12.
`timescale 1ns / 1ps
`default_nettype none
`include "empirical_cdf_index_sampler_unit_defines.svh"

module empirical_cdf_index_sampler_unit #(
  parameter int TABLE_DEPTH = ecdf_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_TABLES  = ecdf_pkg::NUM_TABLES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  ecdf_in_if.sink                           in_item,
  ecdf_out_if.source                        out_item,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ecdf_pkg::APB_AW-1:0]  paddr,
  input  wire logic [ecdf_pkg::APB_DW-1:0]  pwdata,
  output logic      [ecdf_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);

  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = TW + IW;
  localparam int MEM_D = NUM_TABLES * (1 << IW);
  localparam int PW    = ecdf_pkg::PT_W;
  localparam int MW    = 2 * PW;

  ecdf_pkg::ecdf_state_t state_r, state_nxt;

  logic [ecdf_pkg::POP_W-1:0] pop_r [ecdf_pkg::NUM_POP];
  logic [CW-1:0]              cnt_r [NUM_TABLES];
  logic [MW-1:0]              mem   [MEM_D];
  logic [MW-1:0]              rd_data_r;

  logic                        in_acc, ld_acc, smp_acc, in_sel_ok, in_idx_ok;
  logic [TW-1:0]               in_tsel;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [CW-1:0]               in_n;
  logic [ecdf_pkg::POP_W-1:0]  in_pop_raw, in_pop;

  logic [TW-1:0]               t_r;
  logic [ecdf_pkg::SEL_W-1:0]  sel_r;
  logic [ecdf_pkg::U_W-1:0]    u_r;
  logic [CW-1:0]               n_r, i_r, j_r;
  logic                        vld_r;
  logic [ecdf_pkg::POP_W-1:0]  pop_s_r;
  logic [PW-1:0]               xp_r, yp_r, xc_r, yc_r, lo_r, hi_r, span_r, den_r, host_r;
  logic [ecdf_pkg::U_W-1:0]    num_r;
  logic [ecdf_pkg::MUL_W-1:0]  prod_r;

  logic [PW-1:0]               rd_x, rd_y;
  logic                        hit, lt, flat, above;
  logic [PW-1:0]               mul_a, mul_b;
  logic [ecdf_pkg::MUL_W-1:0]  mul_p;
  logic [PW-1:0]               mul_scaled;
  logic [PW-1:0]               host_cl;

  logic                        div_start;
  logic [ecdf_pkg::DVD_W-1:0]  div_dividend;
  logic [ecdf_pkg::DVS_W-1:0]  div_divisor;
  logic [ecdf_pkg::QUO_W-1:0]  div_q;
  ecdf_pkg::div_stat_t         div_stat;

  logic                        out_valid_r, out_load;
  logic [ecdf_pkg::HOST_W-1:0] out_host_r;
  logic [ecdf_pkg::SEL_W-1:0]  out_tbl_r;

  // configuration registers
  assign pready = 1'b1;
  assign prdata = ecdf_pkg::APB_DW'(pop_r[paddr[ecdf_pkg::APB_AW-1:2]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ecdf_pkg::NUM_POP; k++) begin
        pop_r[k] <= ecdf_pkg::POP_W'(1);
      end
    end else if (psel && penable && pwrite && pready) begin
      pop_r[paddr[ecdf_pkg::APB_AW-1:2]] <= pwdata[ecdf_pkg::POP_W-1:0];
    end
  end

  // input decode
  always_comb begin
    in_acc     = in_item.valid && in_item.ready;
    ld_acc     = in_acc && (in_item.mode == ecdf_pkg::MODE_LOAD);
    smp_acc    = in_acc && (in_item.mode == ecdf_pkg::MODE_SAMPLE);
    in_sel_ok  = int'(in_item.table_sel) < NUM_TABLES;
    in_idx_ok  = int'(in_item.entry_index) < TABLE_DEPTH;
    in_tsel    = TW'(in_item.table_sel);
    wr_addr    = {in_tsel, IW'(in_item.entry_index)};
    in_n       = in_sel_ok ? cnt_r[in_tsel] : '0;
    in_pop_raw = pop_r[in_item.table_sel];
    if (in_pop_raw == '0) begin
      in_pop = ecdf_pkg::POP_W'(1);
    end else if (int'(in_pop_raw) > ecdf_pkg::POP_MAX) begin
      in_pop = ecdf_pkg::POP_W'(ecdf_pkg::POP_MAX);
    end else begin
      in_pop = in_pop_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_TABLES; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (ld_acc && in_sel_ok && in_idx_ok && in_item.entry_last) begin
      cnt_r[in_tsel] <= CW'(int'(in_item.entry_index) + 1);
    end
  end

  // point memory
  assign rd_addr = {t_r, i_r[IW-1:0]};

  always_ff @(posedge clk) begin
    if (ld_acc && in_sel_ok && in_idx_ok) begin
      mem[wr_addr] <= {in_item.entry_x, in_item.entry_y};
    end
    rd_data_r <= mem[rd_addr];
  end

  // datapath
  always_comb begin
    rd_x  = rd_data_r[MW-1:PW];
    rd_y  = rd_data_r[PW-1:0];
    hit   = (rd_y > PW'(u_r)) || (j_r == n_r - CW'(1));
    lt    = lo_r < hi_r;
    flat  = (yc_r <= yp_r) || (PW'(u_r) >= yc_r);
    above = PW'(u_r) > yp_r;
    mul_a = xp_r;
    mul_b = pop_s_r;
    if (state_r == ecdf_pkg::S_MHI) begin
      mul_a = xc_r;
    end else if (state_r == ecdf_pkg::S_MQ) begin
      mul_a = span_r;
      mul_b = PW'(num_r);
    end
    mul_p        = ecdf_pkg::MUL_W'(mul_a) * ecdf_pkg::MUL_W'(mul_b);
    mul_scaled   = mul_p[ecdf_pkg::FRAC_W +: PW];
    div_start    = (state_r == ecdf_pkg::S_DIVST);
    div_dividend = ecdf_pkg::DVD_W'({prod_r, 1'b0}) + ecdf_pkg::DVD_W'(den_r);
    div_divisor  = {den_r, 1'b0};
    host_cl      = (host_r >= pop_s_r) ? (pop_s_r - ecdf_pkg::POP_W'(1)) : host_r;
  end

  ecdf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      t_r     <= in_tsel;
      sel_r   <= in_item.table_sel;
      u_r     <= in_item.uniform;
      n_r     <= in_n;
      pop_s_r <= in_pop;
      i_r     <= '0;
      xp_r    <= '0;
      yp_r    <= '0;
      host_r  <= '0;
    end
    if (state_r == ecdf_pkg::S_SCAN) begin
      i_r <= i_r + CW'(1);
      j_r <= i_r;
      if (vld_r) begin
        if (hit) begin
          xc_r <= rd_x;
          yc_r <= rd_y;
        end else begin
          xp_r <= rd_x;
          yp_r <= rd_y;
        end
      end
    end
    if (state_r == ecdf_pkg::S_MLO) begin
      lo_r <= mul_scaled;
    end
    if (state_r == ecdf_pkg::S_MHI) begin
      hi_r <= mul_scaled;
    end
    if (state_r == ecdf_pkg::S_DEC) begin
      span_r <= hi_r - lo_r;
      num_r  <= u_r - yp_r[ecdf_pkg::U_W-1:0];
      den_r  <= yc_r - yp_r;
      if (!lt || (!flat && !above)) begin
        host_r <= lo_r;
      end else if (flat) begin
        host_r <= hi_r;
      end
    end
    if (state_r == ecdf_pkg::S_MQ) begin
      prod_r <= mul_p;
    end
    if (state_r == ecdf_pkg::S_DIVW && div_stat.done) begin
      host_r <= lo_r + PW'(div_q);
    end
  end

  // sequencer
  assign in_item.ready = (state_r == ecdf_pkg::S_IDLE);
  assign out_load      = (state_r == ecdf_pkg::S_DONE) && (!out_valid_r || out_item.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ecdf_pkg::S_IDLE: begin
        if (smp_acc) begin
          state_nxt = (in_sel_ok && in_n != '0) ? ecdf_pkg::S_SCAN : ecdf_pkg::S_DONE;
        end
      end
      ecdf_pkg::S_SCAN: begin
        if (vld_r && hit) begin
          state_nxt = ecdf_pkg::S_MLO;
        end
      end
      ecdf_pkg::S_MLO:   state_nxt = ecdf_pkg::S_MHI;
      ecdf_pkg::S_MHI:   state_nxt = ecdf_pkg::S_DEC;
      ecdf_pkg::S_DEC: begin
        state_nxt = (lt && !flat && above) ? ecdf_pkg::S_MQ : ecdf_pkg::S_DONE;
      end
      ecdf_pkg::S_MQ:    state_nxt = ecdf_pkg::S_DIVST;
      ecdf_pkg::S_DIVST: state_nxt = ecdf_pkg::S_DIVW;
      ecdf_pkg::S_DIVW: begin
        if (div_stat.done) begin
          state_nxt = ecdf_pkg::S_DONE;
        end
      end
      ecdf_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = ecdf_pkg::S_IDLE;
        end
      end
      default: state_nxt = ecdf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ecdf_pkg::S_IDLE;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (smp_acc) begin
        vld_r <= 1'b0;
      end else if (state_r == ecdf_pkg::S_SCAN) begin
        vld_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_host_r <= host_cl[ecdf_pkg::HOST_W-1:0];
      out_tbl_r  <= sel_r;
    end
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.host_index = out_host_r;
  assign out_item.table_used = out_tbl_r;

  `ECDF_ASSERT_NEXT(a_load_no_word, clk, rst_n, ld_acc && !out_valid_r, !out_valid_r)
  `ECDF_ASSERT_NEXT(a_host_below_pop, clk, rst_n, out_load, ecdf_pkg::POP_W'(out_host_r) < pop_s_r)
  `ECDF_ASSERT_IMPL(a_scan_in_count, clk, rst_n, state_r == ecdf_pkg::S_SCAN && vld_r, j_r < n_r)
  `ECDF_ASSERT_IMPL(a_div_in_wait, clk, rst_n, div_stat.busy, state_r == ecdf_pkg::S_DIVW)

endmodule

`default_nettype wire

>>> dv/tb_empirical_cdf_index_sampler_unit.sv
// Self-checking testbench of the empirical CDF index sampler: table loads, samples, populations.
`timescale 1ns / 1ps

module tb_empirical_cdf_index_sampler_unit;
  import ecdf_pkg::*;

  localparam int REG_POP_CLIENT     = 0;
  localparam int REG_POP_SERVER     = 1;
  localparam int REG_POP_CLIENT_ALT = 2;
  localparam int REG_POP_SERVER_ALT = 3;

  localparam logic [1:0] TBL_CLIENT     = 2'd0;
  localparam logic [1:0] TBL_SERVER     = 2'd1;
  localparam logic [1:0] TBL_CLIENT_ALT = 2'd2;
  localparam logic [1:0] TBL_SERVER_ALT = 2'd3;

  localparam int DEPTH         = 64;
  localparam int Q_ONE         = 65536;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_WORDS   = 130;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    ecdf_mode_t  mode;
    logic [1:0]  sel;
    logic [5:0]  idx;
    logic [16:0] x;
    logic [16:0] y;
    logic        last;
    logic [15:0] u;
  } ecdf_word_t;

  typedef struct {
    logic [15:0] host;
    logic [1:0]  tbl;
  } draw_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  ecdf_in_if  in_ch();
  ecdf_out_if out_ch();

  logic [16:0] x_tab [4][DEPTH];
  logic [16:0] y_tab [4][DEPTH];
  bit          written [4][DEPTH];
  int          row_count [4];
  logic [16:0] pop_reg [4];

  draw_result_t pending_draws[$];
  draw_result_t head_draw;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int words_sent = 0;
  int stall_left = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  empirical_cdf_index_sampler_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_item(in_ch),
    .out_item(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb_empirical_cdf_index_sampler_unit: errors");
    $finish;
  end

  function automatic logic [15:0] predict_host_index(int t, logic [15:0] u);
    longint unsigned xp, yp, xc, yc, p, lo, hi, host, span, num, den, uu;
    int n, i;
    xp = 0;
    yp = 0;
    uu = u;
    n = row_count[t];
    if (n == 0) return 16'd0;
    i = 0;
    while (i < n && y_tab[t][i] <= uu) i++;
    if (i == n) i = n - 1;
    if (i > 0) begin
      xp = x_tab[t][i-1];
      yp = y_tab[t][i-1];
    end
    xc = x_tab[t][i];
    yc = y_tab[t][i];
    p = pop_reg[t];
    if (p == 0) p = 1;
    if (p > Q_ONE) p = Q_ONE;
    lo = (xp * p) >> 16;
    hi = (xc * p) >> 16;
    host = lo;
    if (lo < hi) begin
      span = hi - lo;
      if (yc <= yp || uu >= yc) begin
        host = hi;
      end else if (uu > yp) begin
        num = uu - yp;
        den = yc - yp;
        host = lo + (2 * span * num + den) / (2 * den);
      end
    end
    if (host >= p) host = p - 1;
    return host[15:0];
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int receiver_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  always @(negedge clk) begin
    if (stall_left == 0 && !rx_quiet) stall_left = receiver_stall();
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_draws.size() == 0) begin
        $error("host_index word %0d with no sample pending", out_ch.host_index);
        err_cnt++;
      end else begin
        head_draw = pending_draws.pop_front();
        if (out_ch.host_index !== head_draw.host) begin
          $error("host_index: expected %0d, actual %0d", head_draw.host, out_ch.host_index);
          err_cnt++;
        end
        if (out_ch.table_used !== head_draw.tbl) begin
          $error("table_used: expected %0d, actual %0d", head_draw.tbl, out_ch.table_used);
          err_cnt++;
        end
      end
    end
  end

  task automatic apply_word(input ecdf_word_t w);
    draw_result_t r;
    if (w.mode == MODE_LOAD) begin
      x_tab[w.sel][w.idx] = w.x;
      y_tab[w.sel][w.idx] = w.y;
      written[w.sel][w.idx] = 1'b1;
      if (w.last) row_count[w.sel] = int'(w.idx) + 1;
    end else begin
      r.host = predict_host_index(w.sel, w.u);
      r.tbl = w.sel;
      pending_draws.push_back(r);
    end
  endtask

  task automatic send_word(input ecdf_word_t w);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= w.mode;
    in_ch.table_sel   <= w.sel;
    in_ch.entry_index <= w.idx;
    in_ch.entry_x     <= w.x;
    in_ch.entry_y     <= w.y;
    in_ch.entry_last  <= w.last;
    in_ch.uniform     <= w.u;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    apply_word(w);
    words_sent++;
  endtask

  task automatic load_point(input logic [1:0] t, input int idx, input logic [16:0] x,
                            input logic [16:0] y, input logic last);
    ecdf_word_t w;
    w.mode = MODE_LOAD;
    w.sel  = t;
    w.idx  = idx[5:0];
    w.x    = x;
    w.y    = y;
    w.last = last;
    w.u    = 16'($urandom);
    send_word(w);
  endtask

  task automatic draw_sample(input logic [1:0] t, input logic [15:0] u);
    ecdf_word_t w;
    w.mode = MODE_SAMPLE;
    w.sel  = t;
    w.idx  = 6'($urandom);
    w.x    = 17'($urandom);
    w.y    = 17'($urandom);
    w.last = 1'($urandom);
    w.u    = u;
    send_word(w);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input int idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pop_reg[idx] = value[16:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_populations(input logic [31:0] p0, input logic [31:0] p1,
                                     input logic [31:0] p2, input logic [31:0] p3);
    write_register(REG_POP_CLIENT, p0);
    write_register(REG_POP_SERVER, p1);
    write_register(REG_POP_CLIENT_ALT, p2);
    write_register(REG_POP_SERVER_ALT, p3);
  endtask

  function automatic logic [31:0] pick_population();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 20) return 32'd1;
    if (r < 30) return 32'd65536;
    if (r < 35) return 32'd131071;
    if (r < 45) return 32'd65535;
    if (r < 55) return $urandom;
    if (r < 70) return $urandom_range(2, 16);
    return $urandom_range(1, 65536);
  endfunction

  function automatic logic [15:0] pick_uniform(int t);
    int r, k;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    if (r < 55 && row_count[t] > 0) begin
      k = $urandom_range(0, row_count[t] - 1);
      return 16'(int'(y_tab[t][k]) + $urandom_range(0, 2) - 1);
    end
    return 16'($urandom);
  endfunction

  task automatic load_curve(input logic [1:0] t, input int n);
    int xi, yi, yend, k;
    xi = 0;
    yi = 0;
    yend = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 65535) : Q_ONE;
    for (k = 0; k < n; k++) begin
      if (k == n - 1) begin
        xi = Q_ONE;
        yi = yend;
      end else begin
        xi = xi + $urandom_range(0, (Q_ONE - xi) * 2 / (n - k));
        if (xi > Q_ONE) xi = Q_ONE;
        yi = yi + $urandom_range(0, (yend - yi) * 2 / (n - k));
        if (yi > yend) yi = yend;
      end
      load_point(t, k, 17'(xi), 17'(yi), k == n - 1);
    end
  endtask

  task automatic load_noise();
    logic [1:0] t;
    int idx, j;
    bit last;
    t = 2'($urandom);
    idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, DEPTH - 1);
    last = ($urandom_range(0, 99) < 30);
    for (j = 0; j < idx; j++) if (!written[t][j]) last = 1'b0;
    load_point(t, idx, 17'($urandom), 17'($urandom), last);
  endtask

  task automatic test_empty_tables();
    draw_sample(TBL_CLIENT, 16'h0000);
    draw_sample(TBL_SERVER, 16'hFFFF);
    draw_sample(TBL_CLIENT_ALT, 16'h1234);
    draw_sample(TBL_SERVER_ALT, 16'h8000);
    settle();
  endtask

  task automatic test_boundary_tables();
    program_populations(32'd100, 32'd0, 32'd131071, 32'd65536);
    load_point(TBL_CLIENT, 0, 17'h08000, 17'h08000, 1'b0);
    load_point(TBL_CLIENT, 1, 17'h10000, 17'h10000, 1'b1);
    draw_sample(TBL_CLIENT, 16'h0000);
    draw_sample(TBL_CLIENT, 16'h4000);
    draw_sample(TBL_CLIENT, 16'h8000);
    draw_sample(TBL_CLIENT, 16'hFFFF);
    load_point(TBL_SERVER, 0, 17'h1FFFF, 17'h1FFFF, 1'b1);
    draw_sample(TBL_SERVER, 16'h7FFF);
    load_point(TBL_CLIENT_ALT, 0, 17'h10000, 17'h00000, 1'b0);
    load_point(TBL_CLIENT_ALT, 1, 17'h08000, 17'h00000, 1'b1);
    draw_sample(TBL_CLIENT_ALT, 16'h0000);
    load_point(TBL_SERVER_ALT, 0, 17'h04000, 17'h08000, 1'b0);
    load_point(TBL_SERVER_ALT, 1, 17'h0C000, 17'h08000, 1'b1);
    draw_sample(TBL_SERVER_ALT, 16'h9000);
    draw_sample(TBL_SERVER_ALT, 16'h1000);
    draw_sample(TBL_SERVER_ALT, 16'hFFFF);
    settle();
  endtask

  task automatic test_random_traffic();
    int phase, start, r, n;
    logic [1:0] t;
    for (phase = 0; phase < 5; phase++) begin
      program_populations(pick_population(), pick_population(), pick_population(),
                          pick_population());
      tx_quiet = (phase == 2);
      rx_quiet = (phase == 3);
      start = words_sent;
      if (phase == 0) load_curve(2'($urandom), DEPTH);
      while (words_sent - start < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        t = 2'($urandom);
        if (r < 20) begin
          r = $urandom_range(0, 99);
          n = (r < 80) ? $urandom_range(1, 8) :
              (r < 95) ? $urandom_range(9, 32) : $urandom_range(33, DEPTH);
          load_curve(t, n);
        end else if (r < 30) begin
          load_noise();
        end else begin
          draw_sample(t, pick_uniform(t));
        end
      end
      settle();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.table_sel = '0;
    in_ch.entry_index = '0;
    in_ch.entry_x = '0;
    in_ch.entry_y = '0;
    in_ch.entry_last = 1'b0;
    in_ch.uniform = '0;
    out_ch.ready = 1'b1;
    for (int t = 0; t < 4; t++) begin
      row_count[t] = 0;
      pop_reg[t] = 17'd1;
      for (int k = 0; k < DEPTH; k++) written[t][k] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_tables();
    test_boundary_tables();
    test_random_traffic();
    if (err_cnt == 0 && pending_draws.size() == 0) begin
      $display("tb_empirical_cdf_index_sampler_unit: clean");
    end else begin
      $display("tb_empirical_cdf_index_sampler_unit: errors");
    end
    $finish;
  end

endmodule
